### rtl/bole_pkg.sv
package bole_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the command format
    localparam int CMD_W  = 3;
    localparam int POS_W  = 4;
    localparam int STAT_W = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_REPORT     = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Memory read address source
    typedef enum logic [2:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_P1,
        RA_ZERO,
        RA_LAST
    } rd_sel_t;

    // Memory write address and data source
    typedef enum logic {
        WA_IDX,
        WA_LEN
    } wr_addr_t;

    typedef enum logic {
        WD_VALUE,
        WD_READ
    } wr_data_t;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              stat_en;
        logic [STAT_W-1:0] stat;
        logic              idx_len;
        logic              idx_zero;
        logic              idx_inc;
        logic              idx_dec;
        logic              tgt_ld;
        logic              tgt_front;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_en;
        wr_addr_t          wr_addr;
        wr_data_t          wr_data;
        logic              len_inc;
        logic              len_dec;
        logic              front_cap;
        logic              back_cap;
        logic              ends_clr;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             len_zero;
        logic             len_full;
        logic             pos_past;
        logic             idx_at_len;
        logic             idx_at_tgt;
        logic             match;
        logic             dn_last;
    } dp_stat_t;

endpackage

### rtl/bounded_ordered_list_engine_unit.sv
// Channel   Handshake            Signals
// --------  -------------------  ----------------------------------------------
// command   start & !busy        cmd, position, value
// result    done (1-cycle pulse) status, count, front_value, back_value
//
// One command at a time; busy stays high from the accept edge until the
// cycle after done. Report, push back, pop back and a rejected push, insert
// or pop go from decode to the front and back reads, which are skipped
// when the list is empty after the command. A delete, push front, insert
// or pop front first walks the element memory (one read and one write per
// moved entry, a read and a compare per compared entry in a delete).
// Reset empties the list at once; no clearing pass. The receiver cannot
// stall: the result is valid in the done cycle and held until the next
// command changes it.
module bounded_ordered_list_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bole_pkg::CMD_W-1:0]         cmd,
    input  logic [bole_pkg::POS_W-1:0]         position,
    input  logic signed [bole_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic [bole_pkg::STAT_W-1:0]        status,
    output logic [bole_pkg::CNT_W-1:0]         count,
    output logic signed [bole_pkg::DATA_W-1:0] front_value,
    output logic signed [bole_pkg::DATA_W-1:0] back_value
);
    import bole_pkg::*;

    // Command bundle from the sequencer and status flags back from the
    // element store.
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequencer: decodes the latched command, checks the full, empty and
    // position cases, then steps the shift or search walk one entry at a time
    // and finishes by reading the front and back entries (cleared when empty).
    bole_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // Element store: the entry memory with a registered read port, the
    // length and walk index counters, and the result registers that feed
    // the output ports directly.
    bole_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .status      (status),
        .count       (count),
        .front_value (front_value),
        .back_value  (back_value)
    );

    // The length never grows past the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    // An accepted command makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // The result strobe lasts a single cycle and frees the block after it.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // An empty list reports zero at both ends.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && count == '0) |-> (front_value == '0 && back_value == '0))
        else $error("empty list reports nonzero ends");

endmodule

### rtl/bole_dp.sv
module bole_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bole_pkg::dp_cmd_t               ctl,
    output bole_pkg::dp_stat_t              stat,
    input  logic [bole_pkg::CMD_W-1:0]      cmd,
    input  logic [bole_pkg::POS_W-1:0]      position,
    input  logic signed [bole_pkg::DATA_W-1:0] value,
    output logic [bole_pkg::STAT_W-1:0]     status,
    output logic [bole_pkg::CNT_W-1:0]      count,
    output logic signed [bole_pkg::DATA_W-1:0] front_value,
    output logic signed [bole_pkg::DATA_W-1:0] back_value
);
    import bole_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] back_reg;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  tgt_reg;

    logic [CNT_W-1:0]  idx_m1, idx_p1, len_m1;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign idx_m1 = idx_reg - CNT_W'(1);
    assign idx_p1 = idx_reg + CNT_W'(1);
    assign len_m1 = len_reg - CNT_W'(1);

    always_comb
    begin
        unique case (ctl.rd_sel)
            RA_IDX:    rd_addr = idx_reg[ADDR_W-1:0];
            RA_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
            RA_IDX_P1: rd_addr = idx_p1[ADDR_W-1:0];
            RA_ZERO:   rd_addr = '0;
            RA_LAST:   rd_addr = len_m1[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    assign wr_addr = (ctl.wr_addr == WA_LEN) ? len_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data = (ctl.wr_data == WD_READ) ? rd_data_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        priority if (ctl.idx_len)  idx_next = len_reg;
        else if (ctl.idx_zero)     idx_next = '0;
        else if (ctl.idx_inc)      idx_next = idx_p1;
        else if (ctl.idx_dec)      idx_next = idx_m1;
        else                       idx_next = idx_reg;
    end

    always_comb
    begin
        priority if (ctl.len_inc) len_next = len_reg + CNT_W'(1);
        else if (ctl.len_dec)     len_next = len_m1;
        else                      len_next = len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            pos_reg   <= position;
            value_reg <= value;
        end
        if (ctl.tgt_ld)
        begin
            tgt_reg <= ctl.tgt_front ? '0 : CNT_W'(pos_reg) + CNT_W'(1);
        end
        if (ctl.stat_en)
        begin
            status_reg <= ctl.stat;
        end
        if (ctl.ends_clr)
        begin
            front_reg <= '0;
            back_reg  <= '0;
        end
        else
        begin
            if (ctl.front_cap)
            begin
                front_reg <= rd_data_reg;
            end
            if (ctl.back_cap)
            begin
                back_reg <= rd_data_reg;
            end
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.len_zero   = (len_reg == '0);
    assign stat.len_full   = (len_reg >= CNT_W'(CAPACITY));
    assign stat.pos_past   = (CNT_W'(pos_reg) >= len_reg);
    assign stat.idx_at_len = (idx_reg == len_reg);
    assign stat.idx_at_tgt = (idx_reg == tgt_reg);
    assign stat.match      = (rd_data_reg == value_reg);
    assign stat.dn_last    = (idx_p1 >= len_reg);

    assign status      = status_reg;
    assign count       = len_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;

endmodule

### rtl/bole_ctrl.sv
module bole_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bole_pkg::dp_stat_t stat,
    output bole_pkg::dp_cmd_t  ctl,
    output logic               busy,
    output logic               done
);
    import bole_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_UP       = 4'd2;
    localparam logic [3:0] S_UP_WR    = 4'd3;
    localparam logic [3:0] S_SRCH     = 4'd4;
    localparam logic [3:0] S_SRCH_CMP = 4'd5;
    localparam logic [3:0] S_DN       = 4'd6;
    localparam logic [3:0] S_DN_WR    = 4'd7;
    localparam logic [3:0] S_FIN_F    = 4'd8;
    localparam logic [3:0] S_FIN_B    = 4'd9;
    localparam logic [3:0] S_FIN_C    = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.stat_en = 1'b1;
                ctl.stat    = ST_OK;
                state_next  = S_FIN_F;
                unique case (stat.cmd)
                    CMD_PUSH_BACK:
                    begin
                        if (stat.len_full)
                        begin
                            ctl.stat = ST_FULL;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_addr = WA_LEN;
                            ctl.wr_data = WD_VALUE;
                            ctl.len_inc = 1'b1;
                        end
                    end
                    CMD_PUSH_FRONT:
                    begin
                        if (stat.len_full)
                        begin
                            ctl.stat = ST_FULL;
                        end
                        else
                        begin
                            ctl.idx_len   = 1'b1;
                            ctl.tgt_ld    = 1'b1;
                            ctl.tgt_front = 1'b1;
                            state_next    = S_UP;
                        end
                    end
                    CMD_INSERT:
                    begin
                        priority if (stat.len_zero)
                        begin
                            ctl.stat = ST_EMPTY;
                        end
                        else if (stat.len_full)
                        begin
                            ctl.stat = ST_FULL;
                        end
                        else if (stat.pos_past)
                        begin
                            ctl.stat = ST_BADPOS;
                        end
                        else
                        begin
                            ctl.idx_len = 1'b1;
                            ctl.tgt_ld  = 1'b1;
                            state_next  = S_UP;
                        end
                    end
                    CMD_DELETE:
                    begin
                        ctl.idx_zero = 1'b1;
                        state_next   = S_SRCH;
                    end
                    CMD_POP_FRONT:
                    begin
                        if (stat.len_zero)
                        begin
                            ctl.stat = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.idx_zero = 1'b1;
                            state_next   = S_DN;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (stat.len_zero)
                        begin
                            ctl.stat = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.len_dec = 1'b1;
                        end
                    end
                    default:
                    begin
                        // report and the spare code: status ok, no change
                    end
                endcase
            end
            S_UP:
            begin
                if (stat.idx_at_tgt)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = WA_IDX;
                    ctl.wr_data = WD_VALUE;
                    ctl.len_inc = 1'b1;
                    state_next  = S_FIN_F;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_IDX_M1;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = WA_IDX;
                ctl.wr_data = WD_READ;
                ctl.idx_dec = 1'b1;
                state_next  = S_UP;
            end
            S_SRCH:
            begin
                if (stat.idx_at_len)
                begin
                    ctl.stat_en = 1'b1;
                    ctl.stat    = ST_NOTFOUND;
                    state_next  = S_FIN_F;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_IDX;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_DN;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SRCH;
                end
            end
            S_DN:
            begin
                if (stat.dn_last)
                begin
                    ctl.len_dec = 1'b1;
                    state_next  = S_FIN_F;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_IDX_P1;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = WA_IDX;
                ctl.wr_data = WD_READ;
                ctl.idx_inc = 1'b1;
                state_next  = S_DN;
            end
            S_FIN_F:
            begin
                if (stat.len_zero)
                begin
                    ctl.ends_clr = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_ZERO;
                    state_next = S_FIN_B;
                end
            end
            S_FIN_B:
            begin
                ctl.front_cap = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = RA_LAST;
                state_next    = S_FIN_C;
            end
            S_FIN_C:
            begin
                ctl.back_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
